// ----- hdl/pma_pkg.sv -----
// Package for the point-mass attraction step: word types, sequencer states, constants.
// No dependencies.
`default_nettype none
package pma_pkg;

	localparam logic signed [31:0] POS_RESET = 32'sd6553600;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] other_x;
		logic signed [31:0] other_y;
		logic        [31:0] other_mass;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic               saturated;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_DIFF,
		ST_D2_A,
		ST_D2_B,
		ST_SQRT_D,
		ST_DIV_M,
		ST_L2_A,
		ST_L2_B,
		ST_SQRT_L,
		ST_DIV_UX,
		ST_DIV_UY,
		ST_MUL_GX,
		ST_MUL_GY,
		ST_ACC,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/point_mass_attraction_step.sv -----
// Top level of the point-mass attraction step: state registers, bit-serial
// multiplier, square root and divider under one sequencer. Depends on pma_pkg.
//
// Usage: one input channel (in_valid/in_stall/in_word) carries a word with an
// opcode and another body's position and mass. Each accepted word yields exactly
// one output word (out_valid/out_stall/out_word) with the body's position and
// velocity after the item and a saturation flag.
// A tick word, or an attract word whose truncated distance is zero, passes
// through ST_TICK or ST_DIFF and then ST_OUT into the output register; the
// next word can be taken once the sequencer is back in ST_IDLE.
// A full attract word runs eight 32-step passes (four shift-add multiplies for
// the squared sums, two restoring square roots, two gain multiplies) and three
// 64-step restoring divides, plus single states for the difference, the
// velocity update and the output load, all run in turn by the one sequencer.
// The block holds one item at a time: in_stall stays high from acceptance
// until the result has moved into the output register.
// The output register holds its word while out_stall is high; a finished
// result waits in its last state until the register frees, while the next
// input word is taken as soon as the result is registered.
// Reset puts the position at 100.0, 100.0 and the velocity at zero, and
// empties the output register.
`default_nettype none
module point_mass_attraction_step
	import pma_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_word
);

	state_t state_q, state_nxt;

	logic [31:0] px_q, py_q, vx_q, vy_q;
	in_word_t    item_q;
	logic        sat_q;
	logic        neg_x_q, neg_y_q;
	logic [31:0] a_q, b_q;
	logic [63:0] rad_q;      // square-root radicand, shifted out two bits a step
	logic [33:0] rem_q;      // square-root remainder
	logic [31:0] root_q;
	logic [63:0] num_q;      // dividend shifting out, quotient shifting in
	logic [31:0] drem_q;
	logic [31:0] den_q;
	logic [31:0] m_q, ux_q, uy_q, gx_q, gy_q;
	logic [63:0] mca_q;      // multiplicand shifting left
	logic [31:0] mpl_q;      // multiplier shifting right
	logic [63:0] acc_q;
	logic  [5:0] cnt_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic        out_load;
	logic        last;

	// {clamp flag, value}: a value fits when its three top bits agree
	function automatic logic [32:0] clamp34(input logic [33:0] v);
		if (!v[33] && v[32:31] != 2'b00) begin
			clamp34 = {1'b1, 32'h7FFFFFFF};
		end else if (v[33] && v[32:31] != 2'b11) begin
			clamp34 = {1'b1, 32'h80000000};
		end else begin
			clamp34 = {1'b0, v[31:0]};
		end
	endfunction

	logic [32:0] dx, dy, dx_abs, dy_abs;
	logic [31:0] a_abs, b_abs, a_h, b_h;
	logic        near;
	logic [63:0] mul_sum, mca_sh;
	logic [31:0] mpl_sh;
	logic [35:0] rnext, rdiff;
	logic [33:0] rtrial, rem_nxt;
	logic        rfit;
	logic [31:0] root_nxt;
	logic [32:0] dshift, ddiff;
	logic        dfit;
	logic [31:0] drem_nxt;
	logic [63:0] quo_nxt;
	logic [33:0] sum_x, sum_y, acc_x, acc_y;
	logic [32:0] sx, sy, nvx, nvy;

	// one step of each serial unit, and the one-cycle arithmetic
	always_comb begin
		dx     = {item_q.other_x[31], item_q.other_x} - {px_q[31], px_q};
		dy     = {item_q.other_y[31], item_q.other_y} - {py_q[31], py_q};
		dx_abs = dx[32] ? (33'd0 - dx) : dx;
		dy_abs = dy[32] ? (33'd0 - dy) : dy;
		a_abs  = dx_abs[31:0];
		b_abs  = dy_abs[31:0];
		// whole-unit distance is zero: velocity stays as it is
		near   = (a_abs[31:16] == 16'd0) && (b_abs[31:16] == 16'd0);
		// halve both differences when either reaches 2^31
		a_h    = (a_q[31] || b_q[31]) ? {1'b0, a_q[31:1]} : a_q;
		b_h    = (a_q[31] || b_q[31]) ? {1'b0, b_q[31:1]} : b_q;

		mul_sum = acc_q + (mpl_q[0] ? mca_q : 64'd0);
		mca_sh  = {mca_q[62:0], 1'b0};
		mpl_sh  = {1'b0, mpl_q[31:1]};

		rnext    = {rem_q, rad_q[63:62]};
		rtrial   = {root_q, 2'b01};
		rfit     = rnext >= {2'b00, rtrial};
		rdiff    = rnext - {2'b00, rtrial};
		rem_nxt  = rfit ? rdiff[33:0] : rnext[33:0];
		root_nxt = {root_q[30:0], rfit};

		dshift   = {drem_q, num_q[63]};
		dfit     = dshift >= {1'b0, den_q};
		ddiff    = dshift - {1'b0, den_q};
		drem_nxt = dfit ? ddiff[31:0] : dshift[31:0];
		quo_nxt  = {num_q[62:0], dfit};

		sum_x = {{2{px_q[31]}}, px_q} + {{2{vx_q[31]}}, vx_q};
		sum_y = {{2{py_q[31]}}, py_q} + {{2{vy_q[31]}}, vy_q};
		acc_x = {{2{vx_q[31]}}, vx_q} + (neg_x_q ? (34'd0 - {2'b00, gx_q}) : {2'b00, gx_q});
		acc_y = {{2{vy_q[31]}}, vy_q} + (neg_y_q ? (34'd0 - {2'b00, gy_q}) : {2'b00, gy_q});
		sx    = clamp34(sum_x);
		sy    = clamp34(sum_y);
		nvx   = clamp34(acc_x);
		nvy   = clamp34(acc_y);

		last  = cnt_q == 6'd0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = (state_q != ST_IDLE);
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = in_word.opcode ? ST_TICK : ST_DIFF;
			ST_TICK:   state_nxt = ST_OUT;
			ST_DIFF:   state_nxt = near ? ST_OUT : ST_D2_A;
			ST_D2_A:   if (last) state_nxt = ST_D2_B;
			ST_D2_B:   if (last) state_nxt = ST_SQRT_D;
			ST_SQRT_D: if (last) state_nxt = ST_DIV_M;
			ST_DIV_M:  if (last) state_nxt = ST_L2_A;
			ST_L2_A:   if (last) state_nxt = ST_L2_B;
			ST_L2_B:   if (last) state_nxt = ST_SQRT_L;
			ST_SQRT_L: if (last) state_nxt = ST_DIV_UX;
			ST_DIV_UX: if (last) state_nxt = ST_DIV_UY;
			ST_DIV_UY: if (last) state_nxt = ST_MUL_GX;
			ST_MUL_GX: if (last) state_nxt = ST_MUL_GY;
			ST_MUL_GY: if (last) state_nxt = ST_ACC;
			ST_ACC:    state_nxt = ST_OUT;
			ST_OUT: begin
				// hold the result until the output register is free
				out_load = !out_valid_q || !out_stall;
				if (out_load) state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// datapath: each state advances its unit and loads the next one on its last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q    <= POS_RESET;
			py_q    <= POS_RESET;
			vx_q    <= '0;
			vy_q    <= '0;
			item_q  <= '0;
			sat_q   <= 1'b0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			num_q   <= '0;
			drem_q  <= '0;
			den_q   <= '0;
			m_q     <= '0;
			ux_q    <= '0;
			uy_q    <= '0;
			gx_q    <= '0;
			gy_q    <= '0;
			mca_q   <= '0;
			mpl_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					item_q <= in_word;
					sat_q  <= 1'b0;
				end
				ST_TICK: begin
					px_q  <= sx[31:0];
					py_q  <= sy[31:0];
					sat_q <= sx[32] | sy[32];
				end
				ST_DIFF: begin
					neg_x_q <= dx[32];
					neg_y_q <= dy[32];
					a_q     <= a_abs;
					b_q     <= b_abs;
					mca_q   <= {48'd0, a_abs[31:16]};
					mpl_q   <= {16'd0, a_abs[31:16]};
					acc_q   <= '0;
					cnt_q   <= 6'd31;
				end
				ST_D2_A: begin
					acc_q <= mul_sum;
					if (last) begin
						mca_q <= {48'd0, b_q[31:16]};
						mpl_q <= {16'd0, b_q[31:16]};
						cnt_q <= 6'd31;
					end else begin
						mca_q <= mca_sh;
						mpl_q <= mpl_sh;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_D2_B: begin
					acc_q <= mul_sum;
					if (last) begin
						// squared whole-unit distance fits 33 bits; scale by 2^16
						rad_q  <= {mul_sum[47:0], 16'd0};
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= 6'd31;
					end else begin
						mca_q <= mca_sh;
						mpl_q <= mpl_sh;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_SQRT_D: begin
					rad_q  <= {rad_q[61:0], 2'b00};
					rem_q  <= rem_nxt;
					root_q <= root_nxt;
					if (last) begin
						den_q  <= root_nxt;
						num_q  <= {24'd0, item_q.other_mass, 8'd0};
						drem_q <= '0;
						cnt_q  <= 6'd63;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DIV_M: begin
					num_q  <= quo_nxt;
					drem_q <= drem_nxt;
					if (last) begin
						m_q   <= quo_nxt[31:0];
						a_q   <= a_h;
						b_q   <= b_h;
						mca_q <= {32'd0, a_h};
						mpl_q <= a_h;
						acc_q <= '0;
						cnt_q <= 6'd31;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_L2_A: begin
					acc_q <= mul_sum;
					if (last) begin
						mca_q <= {32'd0, b_q};
						mpl_q <= b_q;
						cnt_q <= 6'd31;
					end else begin
						mca_q <= mca_sh;
						mpl_q <= mpl_sh;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_L2_B: begin
					acc_q <= mul_sum;
					if (last) begin
						rad_q  <= mul_sum;
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= 6'd31;
					end else begin
						mca_q <= mca_sh;
						mpl_q <= mpl_sh;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_SQRT_L: begin
					rad_q  <= {rad_q[61:0], 2'b00};
					rem_q  <= rem_nxt;
					root_q <= root_nxt;
					if (last) begin
						den_q  <= root_nxt;
						num_q  <= {2'd0, a_q, 30'd0};
						drem_q <= '0;
						cnt_q  <= 6'd63;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DIV_UX: begin
					if (last) begin
						ux_q   <= quo_nxt[31:0];
						num_q  <= {2'd0, b_q, 30'd0};
						drem_q <= '0;
						cnt_q  <= 6'd63;
					end else begin
						num_q  <= quo_nxt;
						drem_q <= drem_nxt;
						cnt_q  <= cnt_q - 6'd1;
					end
				end
				ST_DIV_UY: begin
					if (last) begin
						uy_q  <= quo_nxt[31:0];
						mca_q <= {32'd0, ux_q};
						mpl_q <= m_q;
						acc_q <= '0;
						cnt_q <= 6'd31;
					end else begin
						num_q  <= quo_nxt;
						drem_q <= drem_nxt;
						cnt_q  <= cnt_q - 6'd1;
					end
				end
				ST_MUL_GX: begin
					if (last) begin
						gx_q  <= mul_sum[61:30];
						mca_q <= {32'd0, uy_q};
						mpl_q <= m_q;
						acc_q <= '0;
						cnt_q <= 6'd31;
					end else begin
						acc_q <= mul_sum;
						mca_q <= mca_sh;
						mpl_q <= mpl_sh;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_MUL_GY: begin
					acc_q <= mul_sum;
					if (last) begin
						gy_q <= mul_sum[61:30];
					end else begin
						mca_q <= mca_sh;
						mpl_q <= mpl_sh;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_ACC: begin
					vx_q  <= nvx[31:0];
					vy_q  <= nvy[31:0];
					sat_q <= nvx[32] | nvy[32];
				end
				default: ;
			endcase
		end
	end

	// output register: load a finished result, drop the word once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_valid_q     <= 1'b1;
			out_q.pos_x     <= px_q;
			out_q.pos_y     <= py_q;
			out_q.vel_x     <= vx_q;
			out_q.vel_y     <= vy_q;
			out_q.saturated <= sat_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word));
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall);
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT));
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT_D || state_q == ST_SQRT_L || state_q == ST_MUL_GX
		|| state_q == ST_MUL_GY) |-> cnt_q <= 6'd31);
`endif

endmodule
`default_nettype wire

// ----- verif/pma_checker.sv -----
// Checker for the point-mass attraction step: watches both channels, predicts
// each output word from its own copy of the body state and compares. Uses pma_pkg.
`default_nettype none
module pma_checker
	import pma_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_stall,
	input  wire in_word_t  in_word,
	input  wire logic      out_valid,
	input  wire logic      out_stall,
	input  wire out_word_t out_word,
	output int             fail_count,
	output int             pending,
	output int             words_seen,
	output int             sat_seen
);

	logic signed [31:0] body_px, body_py, body_vx, body_vy;
	out_word_t expected_words[$];

	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] r, bit_w, rem;
		r = 0;
		rem = v;
		bit_w = 64'd1 << 62;
		while (bit_w > rem) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (rem >= r + bit_w) begin
				rem = rem - (r + bit_w);
				r = (r >> 1) + bit_w;
			end else begin
				r = r >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_sum(input logic signed [63:0] v,
		inout logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Advance the predicted body by one word and return the expected output word.
	function automatic out_word_t predict_body(input in_word_t w);
		logic flag;
		logic signed [63:0] dx, dy, gx, gy;
		logic [63:0] a, b, ai, bi, d2, ds, m, len, ux, uy;
		out_word_t r;
		flag = 1'b0;
		if (w.opcode) begin
			body_px = clamp_sum(64'(body_px) + 64'(body_vx), flag);
			body_py = clamp_sum(64'(body_py) + 64'(body_vy), flag);
		end else begin
			dx = 64'(w.other_x) - 64'(body_px);
			dy = 64'(w.other_y) - 64'(body_py);
			a = dx < 0 ? -dx : dx;
			b = dy < 0 ? -dy : dy;
			ai = a >> 16;
			bi = b >> 16;
			d2 = ai * ai + bi * bi;
			if (d2 != 0) begin
				ds = int_root(d2 << 16);
				m = ({32'd0, w.other_mass} << 8) / ds;
				if (a >= 64'd1 << 31 || b >= 64'd1 << 31) begin
					a = a >> 1;
					b = b >> 1;
				end
				len = int_root(a * a + b * b);
				if (len != 0) begin
					ux = (a << 30) / len;
					uy = (b << 30) / len;
					gx = (ux * m) >> 30;
					gy = (uy * m) >> 30;
					if (dx < 0) gx = -gx;
					if (dy < 0) gy = -gy;
					body_vx = clamp_sum(64'(body_vx) + gx, flag);
					body_vy = clamp_sum(64'(body_vy) + gy, flag);
				end
			end
		end
		r.pos_x = body_px;
		r.pos_y = body_py;
		r.vel_x = body_vx;
		r.vel_y = body_vy;
		r.saturated = flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			body_px = POS_RESET;
			body_py = POS_RESET;
			body_vx = 0;
			body_vy = 0;
			fail_count <= 0;
			words_seen <= 0;
			sat_seen <= 0;
			pending <= 0;
			expected_words.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_words.push_back(predict_body(in_word));
			if (out_valid && !out_stall) begin
				words_seen <= words_seen + 1;
				if (out_word.saturated) sat_seen <= sat_seen + 1;
				if (expected_words.size() == 0) begin
					$error("output word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_words.pop_front();
					if (e != out_word) begin
						fail_count <= fail_count + 1;
						if (e.pos_x != out_word.pos_x)
							$error("pos_x expected %0d got %0d", e.pos_x, out_word.pos_x);
						if (e.pos_y != out_word.pos_y)
							$error("pos_y expected %0d got %0d", e.pos_y, out_word.pos_y);
						if (e.vel_x != out_word.vel_x)
							$error("vel_x expected %0d got %0d", e.vel_x, out_word.vel_x);
						if (e.vel_y != out_word.vel_y)
							$error("vel_y expected %0d got %0d", e.vel_y, out_word.vel_y);
						if (e.saturated != out_word.saturated)
							$error("saturated expected %0d got %0d", e.saturated,
								out_word.saturated);
					end
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Top of the point-mass attraction step testbench: clock, reset, stimulus and
// verdict. Depends on pma_pkg, pma_checker and the block itself.
`default_nettype none
module testbench;
	import pma_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;

	int fail_count, pending, words_seen, sat_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	int cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	point_mass_attraction_step u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	pma_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.fail_count(fail_count), .pending(pending),
		.words_seen(words_seen), .sat_seen(sat_seen)
	);

	// Receiver: stall at random, or hold off entirely during the pressure stretch.
	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL point_mass_attraction_step");
			$finish;
		end
	end

	// Offer one word; drop valid only after it is taken, and only if an idle gap follows.
	task automatic send_word(input in_word_t w);
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return $urandom;
			default: return POS_RESET + $signed($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	function automatic logic [31:0] pick_mass();
		case ($urandom_range(4))
			0: return 32'hffffffff;
			1: return $urandom;
			default: return $urandom_range(32'h00400000);
		endcase
	endfunction

	function automatic in_word_t make_word(input logic op, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] m);
		in_word_t w;
		w.opcode = op;
		w.other_x = x;
		w.other_y = y;
		w.other_mass = m;
		return w;
	endfunction

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(2) == 0)
				send_word(make_word(1'b1, $urandom, $urandom, $urandom));
			else
				send_word(make_word(1'b0, pick_coord(), pick_coord(), pick_mass()));
		end
	endtask

	initial begin
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero distance, sub-unit offsets, extremes, mass limits, tick overflow.
		send_word(make_word(1'b0, POS_RESET, POS_RESET, 32'hffffffff));
		send_word(make_word(1'b0, POS_RESET + 32'hffff, POS_RESET - 32'hffff, 32'h10000));
		send_word(make_word(1'b0, POS_RESET + 32'h10000, POS_RESET, 32'h10000));
		send_word(make_word(1'b0, 32'h7fffffff, 32'h7fffffff, 32'hffffffff));
		send_word(make_word(1'b0, 32'h80000000, 32'h80000000, 32'hffffffff));
		send_word(make_word(1'b0, 32'h80000000, 32'h7fffffff, 32'h0));
		send_word(make_word(1'b0, POS_RESET, POS_RESET + 32'h20000, 32'hffffffff));
		for (int i = 0; i < 8; i++)
			send_word(make_word(1'b0, POS_RESET + 32'h18000, POS_RESET + 32'h18000,
				32'hffffffff));
		for (int i = 0; i < 6; i++)
			send_word(make_word(1'b1, 32'h0, 32'hffffffff, 32'hffffffff));
		send_word(make_word(1'b0, 32'h80000000, 32'h80000000, 32'hffffffff));
		send_word(make_word(1'b1, 32'h0, 32'h0, 32'h0));

		// Pressure: receiver holds off while the sender keeps offering words.
		hold_off = 1'b1;
		fork
			random_phase(4);
			begin
				for (int c = 0; c < 3000; c++) @(posedge clk);
				hold_off = 1'b0;
			end
		join

		send_idle_pct = 11;
		recv_idle_pct = 61;
		random_phase(180);
		send_idle_pct = 61;
		recv_idle_pct = 11;
		random_phase(180);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(190);
		in_valid <= 1'b0;

		// let the checker count the last accepted word before draining
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		waited = 0;
		while (waited < 400) begin
			@(posedge clk);
			waited++;
		end

		$display("Checked %0d output words (%0d saturating) over attract and tick words,",
			words_seen, sat_seen);
		$display("with extremes, zero distance, long receiver hold-off and mixed idling.");
		if (fail_count == 0)
			$display("PASS point_mass_attraction_step");
		else
			$display("FAIL point_mass_attraction_step");
		$finish;
	end

endmodule
`default_nettype wire
